/* hw/rtl/lkhc_pkg.sv */
// Package for the LRU key/handle cache: opcodes, stream field layout and the
// controller-to-datapath command struct. No dependencies.
package lkhc_pkg;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_GET    = 2'd1,
    OP_PUT    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  localparam int unsigned OpW         = 2;
  localparam int unsigned KeyFieldW   = 64;
  localparam int unsigned HandleFieldW = 32;
  localparam int unsigned CapW        = 5;
  localparam logic [CapW-1:0] CapReset = 5'd10;

  // input tdata: key, data_handle; tuser: op
  localparam int unsigned InTdataW  = 96;
  localparam int unsigned InTuserW  = OpW;
  // output tdata: status, present, read_handle, evicted, evicted_key, pad
  localparam int unsigned OutTdataW = 104;
  localparam int unsigned OutPadW   = 5;

  typedef struct packed {
    logic lookup;  // latch item, compare against all entries
    logic update;  // apply the operation to the entries
    logic finish;  // overflow eviction and result register load
  } dp_cmd_t;

endpackage

/* hw/rtl/lru_key_handle_cache_top.sv */
// Top level of the LRU key/handle cache: stream ports, controller, datapath.
// Depends on lkhc_pkg, lkhc_ctrl, lkhc_dp.
//
// Fully associative LRU cache mapping a key digest to a data handle.
// Slave stream: tuser carries op (query, get, put, remove), tdata the key and
// the handle. Master stream: one result item per input item.
// cfg_valid/cfg_data write capacity_in_use (reset 10); cfg_ready is always
// high, writes belong to idle periods.
// Steps: an accepted item is compared against all entries in its lookup step,
// updates the entries in the update step, and evicts on overflow and loads the
// result register in the finish step, which raises tvalid. A new item is taken
// only once the last one has passed its finish step in the controller.
// Reset empties the store at once; no clearing pass.
// While the receiver stalls, the held result stays; the next item is still
// taken and worked up to its finish step, which waits for the result register.
module lru_key_handle_cache_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key[63:0], data_handle[95:64]
  input  logic [lkhc_pkg::InTdataW-1:0]     s_axis_tdata,
  // op[1:0]
  input  logic [lkhc_pkg::InTuserW-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[0], present[1], read_handle[33:2], evicted[34], evicted_key[98:35]
  output logic [lkhc_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lkhc_pkg::CapW-1:0]         cfg_data_i
);

  lkhc_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lkhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lkhc_dp #(
    .MaxEntries (MAX_ENTRIES),
    .KeyBits    (KEY_BITS),
    .HandleBits (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

/* hw/rtl/lkhc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lkhc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lkhc_ctrl.sv */
// Sequencer for the LRU key/handle cache: accept, update, finish.
// Depends on lkhc_pkg.
module lkhc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lkhc_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.lookup = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update = (state_q == ST_UPDATE);
    cmd_o.finish = (state_q == ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.lookup, cmd_o.update, cmd_o.finish}))
    else $error("more than one datapath command");

  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("finished item not presented");

  a_update_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lookup |=> cmd_o.update)
    else $error("lookup not followed by update");

endmodule

/* hw/rtl/lkhc_dp.sv */
// Datapath of the LRU key/handle cache: key lanes with recency ranks, handle
// RAM, capacity register and result register. Depends on lkhc_pkg, lkhc_ram.
module lkhc_dp #(
  parameter int unsigned MaxEntries = 16,
  parameter int unsigned KeyBits    = 64,
  parameter int unsigned HandleBits = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkhc_pkg::dp_cmd_t                 cmd_i,
  input  logic [lkhc_pkg::InTdataW-1:0]     in_tdata_i,
  input  logic [lkhc_pkg::InTuserW-1:0]     in_tuser_i,
  input  logic                              cfg_we_i,
  input  logic [lkhc_pkg::CapW-1:0]         cfg_data_i,
  output logic [lkhc_pkg::OutTdataW-1:0]    out_tdata_o
);

  localparam int unsigned IW = $clog2(MaxEntries);
  localparam int unsigned CW = $clog2(MaxEntries + 1);

  // entry state
  logic [MaxEntries-1:0] valid_q;
  logic [MaxEntries-1:0] valid_d;
  logic [KeyBits-1:0]    lane_key_q [MaxEntries];
  logic [KeyBits-1:0]    lane_key_d [MaxEntries];
  logic [IW-1:0]         rank_q [MaxEntries];
  logic [IW-1:0]         rank_d [MaxEntries];
  logic [CW-1:0]         count_q, count_d;
  logic [lkhc_pkg::CapW-1:0] cap_q;
  logic [CW-1:0]         cap_eff;

  // current item
  lkhc_pkg::op_e         op_q;
  logic [KeyBits-1:0]    in_key;
  logic [KeyBits-1:0]    item_key_q;
  logic [HandleBits-1:0] in_handle;
  logic [HandleBits-1:0] item_handle_q;

  // lookup results
  logic [MaxEntries-1:0] hit_vec, hit_vec_q;
  logic [MaxEntries-1:0] free_vec, free_vec_q;
  logic [MaxEntries-1:0] lru_vec, lru_vec_q;
  logic                  free_taken;
  logic [KeyBits-1:0]    lru_key, lru_key_q;
  logic [IW-1:0]         hit_rank, hit_rank_q;
  logic [IW-1:0]         hit_idx, hit_idx_q;
  logic [IW-1:0]         free_idx, free_idx_q;
  logic [IW-1:0]         lru_idx, lru_idx_q;
  logic                  hit_any_q, free_any_q;

  // eviction and result
  logic                  evict_q, evict_d;
  logic [KeyBits-1:0]    evk_q, evk_d;
  logic                  done_q, done_d;
  logic                  res_status_q, res_present_q, res_evicted_q;
  logic [lkhc_pkg::HandleFieldW-1:0] res_handle_q;
  logic [lkhc_pkg::KeyFieldW-1:0]    res_evk_q;

  // handle store
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr;
  logic [HandleBits-1:0] ram_rdata;

  assign in_key    = in_tdata_i[KeyBits-1:0];
  assign in_handle = HandleBits'(64'(in_tdata_i[lkhc_pkg::InTdataW-1:lkhc_pkg::KeyFieldW]));

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > 32'(MaxEntries)) begin
      cap_eff = CW'(MaxEntries);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  // parallel compare over all lanes; lru is the valid lane ranked count-1
  always_comb begin
    free_vec   = '0;
    free_taken = 1'b0;
    lru_key    = '0;
    hit_rank   = '0;
    hit_idx    = '0;
    free_idx   = '0;
    lru_idx    = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_vec[i] = valid_q[i] && (lane_key_q[i] == in_key);
      lru_vec[i] = valid_q[i] && (CW'(rank_q[i]) == count_q - CW'(1));
      if (!valid_q[i] && !free_taken) begin
        free_vec[i] = 1'b1;
        free_taken  = 1'b1;
      end
    end
    for (int i = 0; i < MaxEntries; i++) begin
      if (lru_vec[i]) begin
        lru_key = lru_key | lane_key_q[i];
        lru_idx = IW'(i);
      end
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_idx  = IW'(i);
      end
      if (free_vec[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    valid_d    = valid_q;
    lane_key_d = lane_key_q;
    rank_d     = rank_q;
    count_d    = count_q;
    evict_d    = evict_q;
    evk_d      = evk_q;
    done_d     = done_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = hit_idx_q;
    if (cmd_i.lookup) begin
      evict_d = 1'b0;
      evk_d   = '0;
      done_d  = 1'b0;
    end
    if (cmd_i.update) begin
      case (op_q)
        lkhc_pkg::OP_GET, lkhc_pkg::OP_PUT: begin
          if (hit_any_q) begin
            ram_re = (op_q == lkhc_pkg::OP_GET);
            ram_we = (op_q == lkhc_pkg::OP_PUT);
            for (int i = 0; i < MaxEntries; i++) begin
              if (hit_vec_q[i]) begin
                rank_d[i] = '0;
              end else if (valid_q[i] && rank_q[i] < hit_rank_q) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end
            end
          end else if (op_q == lkhc_pkg::OP_PUT && free_any_q) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_q;
            count_d   = count_q + CW'(1);
            for (int i = 0; i < MaxEntries; i++) begin
              if (free_vec_q[i]) begin
                valid_d[i]    = 1'b1;
                lane_key_d[i] = item_key_q;
                rank_d[i]     = '0;
              end else if (valid_q[i]) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end
            end
          end else if (op_q == lkhc_pkg::OP_PUT) begin
            // store full: reuse the least recent slot
            ram_we    = 1'b1;
            ram_waddr = lru_idx_q;
            evict_d   = 1'b1;
            evk_d     = lru_key_q;
            done_d    = 1'b1;
            for (int i = 0; i < MaxEntries; i++) begin
              if (lru_vec_q[i]) begin
                lane_key_d[i] = item_key_q;
                rank_d[i]     = '0;
              end else if (valid_q[i]) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end
            end
          end
        end
        lkhc_pkg::OP_REMOVE: begin
          if (hit_any_q) begin
            count_d = count_q - CW'(1);
            for (int i = 0; i < MaxEntries; i++) begin
              if (hit_vec_q[i]) begin
                valid_d[i] = 1'b0;
              end else if (valid_q[i] && rank_q[i] > hit_rank_q) begin
                rank_d[i] = rank_q[i] - IW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.finish && op_q == lkhc_pkg::OP_PUT && !done_q && count_q > cap_eff) begin
      // lru lane sits at rank count-1, so no other rank moves
      count_d = count_q - CW'(1);
      evict_d = 1'b1;
      evk_d   = lru_key;
      for (int i = 0; i < MaxEntries; i++) begin
        if (lru_vec[i]) begin
          valid_d[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxEntries; i++) begin
        valid_q[i] <= 1'b0;
      end
      count_q <= '0;
      cap_q   <= lkhc_pkg::CapReset;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_key_q <= lane_key_d;
    rank_q     <= rank_d;
    evict_q    <= evict_d;
    evk_q      <= evk_d;
    done_q     <= done_d;
    if (cmd_i.lookup) begin
      op_q          <= lkhc_pkg::op_e'(in_tuser_i);
      item_key_q    <= in_key;
      item_handle_q <= in_handle;
      hit_vec_q     <= hit_vec;
      free_vec_q    <= free_vec;
      lru_vec_q     <= lru_vec;
      lru_key_q     <= lru_key;
      hit_rank_q    <= hit_rank;
      hit_idx_q     <= hit_idx;
      free_idx_q    <= free_idx;
      lru_idx_q     <= lru_idx;
      hit_any_q     <= |hit_vec;
      free_any_q    <= free_taken;
    end
    if (cmd_i.finish) begin
      res_status_q  <= (op_q == lkhc_pkg::OP_GET) && !hit_any_q;
      res_present_q <= hit_any_q;
      res_handle_q  <= ((op_q == lkhc_pkg::OP_GET) && hit_any_q) ?
                       lkhc_pkg::HandleFieldW'(64'(ram_rdata)) : '0;
      res_evicted_q <= evict_d;
      res_evk_q     <= lkhc_pkg::KeyFieldW'(64'(evk_d));
    end
  end

  lkhc_ram #(
    .Width (HandleBits),
    .Depth (MaxEntries)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_handle_q),
    .re_i    (ram_re),
    .raddr_i (hit_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_tdata_o = {{lkhc_pkg::OutPadW{1'b0}}, res_evk_q, res_evicted_q, res_handle_q,
                        res_present_q, res_status_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MaxEntries))
    else $error("entry count above store size");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("entry count differs from valid lanes");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(hit_vec_q))
    else $error("key held in more than one lane");

  a_evict_put_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && evict_d) |-> (op_q == lkhc_pkg::OP_PUT))
    else $error("eviction outside a put");

endmodule
